### src/hmm_scaled_forward_step_core_macros.svh
// ----------------------------------------------------------------------------
// HMM scaled forward step: assertion macros
// Shorthand for the concurrent checks on the core's ports. Both macros sample
// on the rising edge of clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HMM_SCALED_FORWARD_STEP_CORE_MACROS_SVH
`define HMM_SCALED_FORWARD_STEP_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsf port check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsf port check failed");

`endif

### src/hsf_pkg.sv
// ----------------------------------------------------------------------------
// HMM scaled forward step: shared package
// Sizes, fixed-point widths, input modes, sequencer states and the command
// word of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package hsf_pkg;

  // Model size and probability format (Q0.PROB_BITS, scale in Q3.PROB_BITS).
  localparam int NUM_STATES = 8;
  localparam int PROB_BITS  = 16;
  localparam int STATE_W    = $clog2(NUM_STATES);
  localparam int IDX_W      = 3;
  localparam int SCALE_W    = PROB_BITS + 3;
  localparam int PROD_W     = SCALE_W + PROB_BITS;
  localparam int ACC_W      = 2 * PROB_BITS + STATE_W;
  localparam int RAM_AW     = 2 * STATE_W;
  localparam int RAM_DEPTH  = NUM_STATES * NUM_STATES;
  localparam int CNT_W      = $clog2(NUM_STATES + 2);
  localparam int DIV_CNT_W  = $clog2(PROB_BITS);

  // Port packing.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;

  typedef logic [PROB_BITS-1:0] prob_t;
  typedef logic [SCALE_W-1:0]   scale_t;

  localparam prob_t  PROB_MAX  = '1;
  localparam scale_t SCALE_MAX = '1;

  // Input item kinds.
  typedef enum logic [1:0] {
    MODE_TRANS = 2'd0,
    MODE_PRIOR = 2'd1,
    MODE_OBS   = 2'd2
  } mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SRND,
    ST_SMUL,
    ST_UPD,
    ST_SUM,
    ST_TOT,
    ST_DIV,
    ST_DWAIT,
    ST_EMIT
  } state_t;

  // Command word of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clr;       // clear the accumulator
    logic mul_en;    // capture op_a * op_b into the product register
    logic acc_prod;  // add the product register into the accumulator
    logic acc_add;   // add the direct addend into the accumulator
  } mac_cmd_t;

endpackage

### src/hmm_scaled_forward_step_core.sv
// ----------------------------------------------------------------------------
// HMM scaled forward step core
// Scaled forward recursion of an 8-state hidden Markov model in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries load and observation transactions. A transition
//   or prior load is written while idle. Observations arrive one state at a
//   time; the one for the last state closes the position and the core then
//   streams NUM_STATES results (state index, normalized alpha, scale, zero
//   flag) with tlast on the last state.
//   Work: a recursive observation has the shared multiply-accumulate unit
//   walk the transition memory one entry a cycle; a first-position
//   observation skips that walk. Closing a position sums the scale and then
//   runs the bit-serial divider for each state, which is cut short when the
//   scale is zero or the quotient saturates. No transaction is taken until
//   the last result of the position has been emitted.
//   The core takes one input transaction at a time; in_tready is high only
//   while it is idle. A stalled receiver holds the result in the output
//   register and halts the sequencer until the result is taken.
//   Reset clears the sequencer, the output valid and both alpha vectors; the
//   transition table and priors must be loaded before use.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_core
  import hsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] from_state, [5:3] to_state, [21:6] value, [23:22] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode, [2] new_sequence
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] state_index, [18:3] alpha, [37:19] scale, [39:38] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] zero_sum
  output logic [0:0]             out_tuser,
  output logic                   out_tlast
);

  localparam logic [CNT_W-1:0]   CNT_N    = CNT_W'(NUM_STATES);
  localparam logic [CNT_W-1:0]   CNT_N1   = CNT_W'(NUM_STATES + 1);
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(NUM_STATES - 1);
  localparam logic [CNT_W-1:0]   CNT_TWO  = CNT_W'(2);
  localparam logic [STATE_W-1:0] IDX_LAST = STATE_W'(NUM_STATES - 1);

  // Input field decode.
  logic [IDX_W-1:0]   in_from;
  logic [IDX_W-1:0]   in_to;
  prob_t              in_val;
  mode_t              in_mode;
  logic               in_first;
  logic               to_ok;
  logic               from_ok;

  assign in_from  = in_tdata[2:0];
  assign in_to    = in_tdata[5:3];
  assign in_val   = in_tdata[21:6];
  assign in_mode  = mode_t'(in_tuser[1:0]);
  assign in_first = in_tuser[2];
  assign to_ok    = (int'(in_to) < NUM_STATES);
  assign from_ok  = (int'(in_from) < NUM_STATES);

  // State.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STATE_W-1:0] to_r, to_nxt;
  prob_t              val_r, val_nxt;
  scale_t             s_r, s_nxt;
  scale_t             total_r, total_nxt;
  prob_t              prior_r [NUM_STATES];
  prob_t              prev_r  [NUM_STATES];
  scale_t             cur_r   [NUM_STATES];

  // Output register.
  logic               out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  prob_t              out_alpha_r, out_alpha_nxt;
  scale_t             out_scale_r, out_scale_nxt;
  logic               out_zero_r, out_zero_nxt;
  logic               out_last_r, out_last_nxt;

  // Control and datapath wires.
  logic [STATE_W-1:0] cnt_idx;
  logic [CNT_W-1:0]   cnt_m1;
  logic [STATE_W-1:0] cnt_m1_idx;
  logic               obs_acc;
  logic               out_free;
  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr;
  logic [RAM_AW-1:0]  ram_raddr;
  prob_t              ram_rdata;
  logic               prior_we;
  logic               cur_we;
  logic               prev_we;
  logic               out_load;
  logic               div_start;
  logic               div_done;
  prob_t              div_quot;
  mac_cmd_t           mac_cmd;
  scale_t             op_a;
  prob_t              op_b;
  scale_t             addend;
  scale_t             prod_rnd;
  scale_t             acc_rnd;
  scale_t             acc_sat;

  assign cnt_idx    = cnt_r[STATE_W-1:0];
  assign cnt_m1     = cnt_r - 1'b1;
  assign cnt_m1_idx = cnt_m1[STATE_W-1:0];
  assign obs_acc    = in_tvalid && (in_mode == MODE_OBS) && to_ok;
  assign out_free   = !out_vld_r || out_tready;
  assign ram_waddr  = {in_from[STATE_W-1:0], in_to[STATE_W-1:0]};

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (obs_acc) begin
          state_nxt = in_first ? ST_SMUL : ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_r == CNT_N1) begin
          state_nxt = ST_SRND;
        end
      end
      ST_SRND: state_nxt = ST_SMUL;
      ST_SMUL: state_nxt = ST_UPD;
      ST_UPD: begin
        state_nxt = (to_r == IDX_LAST) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_TOT;
        end
      end
      ST_TOT: state_nxt = ST_DIV;
      ST_DIV: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (cnt_r == CNT_LAST) ? ST_IDLE : ST_DIV;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: strobes and operand selection of the shared units.
  always_comb begin
    in_tready = 1'b0;
    mac_cmd   = '0;
    ram_we    = 1'b0;
    prior_we  = 1'b0;
    cur_we    = 1'b0;
    prev_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    op_a      = s_r;
    op_b      = val_r;
    addend    = cur_r[cnt_idx];
    ram_raddr = {cnt_idx, to_r};
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        mac_cmd.clr = 1'b1;
        ram_we   = in_tvalid && (in_mode == MODE_TRANS) && to_ok && from_ok;
        prior_we = in_tvalid && (in_mode == MODE_PRIOR) && to_ok;
      end
      ST_MAC: begin
        // Read i is issued at count i, multiplied at i+1, added at i+2.
        op_a             = SCALE_W'(ram_rdata);
        op_b             = prev_r[cnt_m1_idx];
        mac_cmd.mul_en   = (cnt_r != '0) && (cnt_r <= CNT_N);
        mac_cmd.acc_prod = (cnt_r >= CNT_TWO);
      end
      ST_SMUL: begin
        mac_cmd.mul_en = 1'b1;
      end
      ST_UPD: begin
        cur_we      = 1'b1;
        mac_cmd.clr = 1'b1;
      end
      ST_SUM: begin
        mac_cmd.acc_add = 1'b1;
      end
      ST_DIV: begin
        div_start = 1'b1;
      end
      ST_EMIT: begin
        out_load = out_free;
        prev_we  = out_free;
      end
      default: begin
      end
    endcase
  end

  // Datapath register next values.
  always_comb begin
    cnt_nxt       = cnt_r;
    to_nxt        = to_r;
    val_nxt       = val_r;
    s_nxt         = s_r;
    total_nxt     = total_r;
    out_idx_nxt   = out_idx_r;
    out_alpha_nxt = out_alpha_r;
    out_scale_nxt = out_scale_r;
    out_zero_nxt  = out_zero_r;
    out_last_nxt  = out_last_r;
    out_vld_nxt   = out_tready ? 1'b0 : out_vld_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (obs_acc) begin
          to_nxt  = in_to[STATE_W-1:0];
          val_nxt = in_val;
          s_nxt   = SCALE_W'(prior_r[in_to[STATE_W-1:0]]);
        end
      end
      ST_MAC:  cnt_nxt = cnt_r + 1'b1;
      ST_SRND: s_nxt = acc_rnd;
      ST_UPD:  cnt_nxt = '0;
      ST_SUM:  cnt_nxt = cnt_r + 1'b1;
      ST_TOT: begin
        cnt_nxt   = '0;
        total_nxt = acc_sat;
      end
      ST_EMIT: begin
        if (out_free) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_vld_nxt   = 1'b1;
      out_idx_nxt   = IDX_W'(cnt_idx);
      out_alpha_nxt = div_quot;
      out_scale_nxt = total_r;
      out_zero_nxt  = (total_r == '0);
      out_last_nxt  = (cnt_r == CNT_LAST);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    to_r        <= to_nxt;
    val_r       <= val_nxt;
    s_r         <= s_nxt;
    total_r     <= total_nxt;
    out_idx_r   <= out_idx_nxt;
    out_alpha_r <= out_alpha_nxt;
    out_scale_r <= out_scale_nxt;
    out_zero_r  <= out_zero_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Prior vector, written by load transactions.
  always_ff @(posedge clk) begin
    if (prior_we) begin
      prior_r[in_to[STATE_W-1:0]] <= in_val;
    end
  end

  // Unnormalized and normalized alpha vectors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        cur_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      if (cur_we) begin
        cur_r[to_r] <= prod_rnd;
      end
      if (prev_we) begin
        prev_r[cnt_idx] <= div_quot;
      end
    end
  end

  hsf_trans_ram u_trans_ram (
    .clk       (clk),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (in_val),
    .raddr     (ram_raddr),
    .rd_data_r (ram_rdata)
  );

  hsf_mul_acc u_mul_acc (
    .clk      (clk),
    .cmd      (mac_cmd),
    .op_a     (op_a),
    .op_b     (op_b),
    .addend   (addend),
    .prod_rnd (prod_rnd),
    .acc_rnd  (acc_rnd),
    .acc_sat  (acc_sat)
  );

  hsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_r[cnt_idx]),
    .divisor  (total_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Result stream.
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_scale_r, out_alpha_r, out_idx_r};
  assign out_tuser  = out_zero_r;
  assign out_tlast  = out_last_r;

endmodule

### src/hsf_trans_ram.sv
// ----------------------------------------------------------------------------
// HMM scaled forward step: transition table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsf_trans_ram
  import hsf_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [RAM_AW-1:0] waddr,
  input  prob_t             wdata,
  input  logic [RAM_AW-1:0] raddr,
  output prob_t             rd_data_r
);

  prob_t mem [RAM_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
  end

endmodule

### src/hsf_mul_acc.sv
// ----------------------------------------------------------------------------
// HMM scaled forward step: shared multiply-accumulate unit
// One registered multiplier and one accumulator, with round-half-up and
// saturation to Q3 of the product and the sum; the sum also comes unrounded.
// ----------------------------------------------------------------------------
module hsf_mul_acc
  import hsf_pkg::*;
(
  input  logic     clk,
  input  mac_cmd_t cmd,
  input  scale_t   op_a,
  input  prob_t    op_b,
  input  scale_t   addend,
  output scale_t   prod_rnd,
  output scale_t   acc_rnd,
  output scale_t   acc_sat
);

  localparam int PRND_W = PROD_W + 1;
  localparam int ARND_W = ACC_W + 1;
  localparam logic [PRND_W-1:0] PHALF = PRND_W'(1) << (PROB_BITS - 1);
  localparam logic [ARND_W-1:0] AHALF = ARND_W'(1) << (PROB_BITS - 1);

  logic [PROD_W-1:0]          prod_r;
  logic [PROD_W-1:0]          prod_nxt;
  logic [ACC_W-1:0]           acc_r;
  logic [ACC_W-1:0]           acc_nxt;
  logic [PRND_W-1:0]          prod_sum;
  logic [PRND_W-PROB_BITS-1:0] prod_sh;
  logic [ARND_W-1:0]          acc_sum;
  logic [ARND_W-PROB_BITS-1:0] acc_sh;

  // Multiplier and accumulator next values.
  always_comb begin
    prod_nxt = prod_r;
    if (cmd.mul_en) begin
      prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);
    end
    acc_nxt = acc_r;
    if (cmd.clr) begin
      acc_nxt = '0;
    end else if (cmd.acc_prod) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_nxt = acc_r + ACC_W'(addend);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Product rounded to PROB_BITS fraction bits and saturated to Q3.
  always_comb begin
    prod_sum = {1'b0, prod_r} + PHALF;
    prod_sh  = prod_sum[PRND_W-1:PROB_BITS];
    if ((prod_sh >> SCALE_W) != '0) begin
      prod_rnd = SCALE_MAX;
    end else begin
      prod_rnd = prod_sh[SCALE_W-1:0];
    end
  end

  // Accumulated product sum rounded once and saturated to Q3.
  always_comb begin
    acc_sum = {1'b0, acc_r} + AHALF;
    acc_sh  = acc_sum[ARND_W-1:PROB_BITS];
    if ((acc_sh >> SCALE_W) != '0) begin
      acc_rnd = SCALE_MAX;
    end else begin
      acc_rnd = acc_sh[SCALE_W-1:0];
    end
  end

  // Plain accumulated sum saturated to Q3 (scale of a position).
  always_comb begin
    if ((acc_r >> SCALE_W) != '0) begin
      acc_sat = SCALE_MAX;
    end else begin
      acc_sat = acc_r[SCALE_W-1:0];
    end
  end

endmodule

### src/hsf_div.sv
// ----------------------------------------------------------------------------
// HMM scaled forward step: normalizing divider
// Restoring division of an alpha by the scale, one quotient bit per cycle,
// then a round-half-up step with saturation to the Q0 maximum.
// ----------------------------------------------------------------------------
module hsf_div
  import hsf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  scale_t dividend,
  input  scale_t divisor,
  output logic   done,
  output prob_t  quot
);

  localparam logic [DIV_CNT_W-1:0] CNT_END = DIV_CNT_W'(PROB_BITS - 1);

  logic                 busy_r, busy_nxt;
  logic                 rnd_r, rnd_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  scale_t               rem_r, rem_nxt;
  scale_t               den_r, den_nxt;
  prob_t                frac_r, frac_nxt;
  prob_t                quot_r, quot_nxt;
  logic [SCALE_W:0]     rem2;
  logic [SCALE_W:0]     rem_sub;
  logic                 ge;

  // Trial subtraction of the shifted remainder.
  always_comb begin
    rem2    = {rem_r, 1'b0};
    rem_sub = rem2 - {1'b0, den_r};
    ge      = (rem2 >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    rnd_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    frac_nxt = frac_r;
    quot_nxt = quot_r;
    if (start) begin
      // Zero scale gives zero; a quotient of one or more saturates.
      den_nxt = divisor;
      if (divisor == '0) begin
        quot_nxt = '0;
        done_nxt = 1'b1;
      end else if (dividend >= divisor) begin
        quot_nxt = PROB_MAX;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = dividend;
        frac_nxt = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[SCALE_W-1:0] : rem2[SCALE_W-1:0];
      frac_nxt = {frac_r[PROB_BITS-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_END) begin
        busy_nxt = 1'b0;
        rnd_nxt  = 1'b1;
      end
    end else if (rnd_r) begin
      // Round half up on the final remainder.
      done_nxt = 1'b1;
      if (ge && (frac_r == PROB_MAX)) begin
        quot_nxt = PROB_MAX;
      end else begin
        quot_nxt = frac_r + prob_t'(ge);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    frac_r <= frac_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### src/hsf_checker.sv
// ----------------------------------------------------------------------------
// HMM scaled forward step: port checker
// Watches the result stream of the core and checks that results hold under
// a stall and that the zero flag, scale, alpha and tlast agree.
// ----------------------------------------------------------------------------
`include "hmm_scaled_forward_step_core_macros.svh"

module hsf_checker
  import hsf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser,
  input logic                   out_tlast
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_STATES - 1);

  // A stalled result transaction keeps its contents.
  `HSF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // The zero flag is set exactly when the scale is zero.
  `HSF_ASSERT_NOW(a_zero_flag, out_tvalid, out_tuser[0] == (out_tdata[37:19] == '0))

  // A zero scale forces every normalized alpha to zero.
  `HSF_ASSERT_NOW(a_zero_alpha, out_tvalid && out_tuser[0], out_tdata[18:3] == '0)

  // tlast marks the result of the final state only.
  `HSF_ASSERT_NOW(a_last_idx, out_tvalid, out_tlast == (out_tdata[2:0] == IDX_LAST))

endmodule

bind hmm_scaled_forward_step_core hsf_checker u_hsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
